### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// types, character codes and rank helpers of the infix to postfix converter
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    KIND_LETTER,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_OP
  } kind_e;

  typedef enum logic [1:0] {
    S_CMD,
    S_POP,
    S_FLUSH
  } back_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] rank;
    logic [7:0] ch;
    logic       eoe;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       term;
    logic       ovf;
  } result_t;

  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    case (ch)
      CH_CARET:           r = 2'd3;
      CH_STAR, CH_SLASH:  r = 2'd2;
      CH_PLUS, CH_MINUS:  r = 2'd1;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  endfunction

endpackage

### rtl/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard infix to postfix converter with an on-chip operator stack
// ----------------------------------------------------------------------------
// usage: write characters with push while full is low; take results with pop
// while empty is low, oldest first. each item may release zero or more
// results; last_of_run marks the final result of an item, and an item with
// end_of_expression set flushes the stack and ends with a terminator result
// (out_char 0, is_terminator 1, overflow_seen reporting any dropped push).
// a letter passes the registered command and result queues. the stack engine
// takes a letter or '(' in its command state; ')' or an operator moves it to a
// pop state that pops entries down to a '(' or a lower rank, then drops the
// '(' or pushes the operator; an end marker then flushes the stack and adds the
// terminator. one stack push or pop per cycle while the result queue has room.
// a two-entry command queue keeps intake going while the stack engine works,
// and a two-entry result queue keeps it going while the receiver stalls;
// a stalled receiver holds the engine, then fills the command queue (full).
// reset empties both queues, the stack and the overflow flag; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expression_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o,
  output logic       is_terminator_o,
  output logic       overflow_seen_o
);

  import i2p_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res_in;
  result_t res_out;
  logic [$bits(result_t)-1:0] res_raw;
  logic    res_push;
  logic    res_full;

  i2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_char_i   (in_char_i),
    .eoe_i       (end_of_expression_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  i2p_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out         = result_t'(res_raw);
  assign out_char_o      = res_out.ch;
  assign last_of_run_o   = res_out.last;
  assign is_terminator_o = res_out.term;
  assign overflow_seen_o = res_out.ovf;

endmodule

### rtl/i2p_fifo.sv
// ----------------------------------------------------------------------------
// i2p_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module i2p_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/i2p_front.sv
// ----------------------------------------------------------------------------
// i2p_front
// takes input characters, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module i2p_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    in_char_i,
  input  logic          eoe_i,
  output logic          full_o,
  input  logic          cmd_pop_i,
  output i2p_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o
);

  import i2p_pkg::*;

  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;
  logic                cmd_empty;

  always_comb begin
    cmd_in.ch   = in_char_i;
    cmd_in.eoe  = eoe_i;
    cmd_in.rank = rank_of(in_char_i);
    if (is_letter(in_char_i)) begin
      cmd_in.kind = KIND_LETTER;
    end else if (in_char_i == CH_LPAREN) begin
      cmd_in.kind = KIND_LPAREN;
    end else if (in_char_i == CH_RPAREN) begin
      cmd_in.kind = KIND_RPAREN;
    end else begin
      cmd_in.kind = KIND_OP;
    end
  end

  i2p_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty)
  );

  assign cmd_o       = cmd_t'(cmd_raw);
  assign cmd_valid_o = !cmd_empty;

endmodule

### rtl/i2p_back.sv
// ----------------------------------------------------------------------------
// i2p_back
// operator stack engine: pushes, pops and flushes, one stack access per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2p_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  i2p_pkg::cmd_t    cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  output i2p_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i
);

  import i2p_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  back_state_e   state_q, state_d;
  cmd_t          cur_q, cur_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    top_q, top_d;
  logic [7:0]    below_q;
  logic [7:0]    stack_mem [STACK_DEPTH];

  logic          do_push, do_pop;
  logic [7:0]    push_ch;
  logic          nonempty, below_ok;
  logic          pop_cond, next_cond;
  logic [CW-1:0] rd_full;
  logic [AW-1:0] rd_addr;

  assign nonempty = (count_q != '0);
  assign below_ok = (count_q > CW'(1));

  always_comb begin
    if (cur_q.kind == KIND_RPAREN) begin
      pop_cond  = nonempty && (top_q != CH_LPAREN);
      next_cond = below_ok && (below_q != CH_LPAREN);
    end else begin
      pop_cond  = nonempty && (cur_q.rank <= rank_of(top_q));
      next_cond = below_ok && (cur_q.rank <= rank_of(below_q));
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    ovf_d      = ovf_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    push_ch    = cur_q.ch;

    unique case (state_q)
      S_CMD: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            KIND_LETTER: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                res_o.ch   = cmd_i.ch;
                res_o.last = !cmd_i.eoe;
                cmd_pop_o  = 1'b1;
                if (cmd_i.eoe) begin
                  state_d = S_FLUSH;
                end
              end
            end
            KIND_LPAREN: begin
              cmd_pop_o = 1'b1;
              do_push   = 1'b1;
              push_ch   = cmd_i.ch;
              if (cmd_i.eoe) begin
                state_d = S_FLUSH;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
              cur_d     = cmd_i;
              state_d   = S_POP;
            end
          endcase
        end
      end
      S_POP: begin
        if (pop_cond) begin
          if (!res_full_i) begin
            res_push_o = 1'b1;
            res_o.ch   = top_q;
            res_o.last = !cur_q.eoe && !next_cond;
            do_pop     = 1'b1;
          end
        end else begin
          // closing paren drops its opening paren, an operator goes on the stack
          if (cur_q.kind == KIND_RPAREN) begin
            do_pop = nonempty;
          end else begin
            do_push = 1'b1;
          end
          state_d = cur_q.eoe ? S_FLUSH : S_CMD;
        end
      end
      S_FLUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (nonempty) begin
            res_o.ch = top_q;
            do_pop   = 1'b1;
          end else begin
            res_o.ch   = CH_NUL;
            res_o.last = 1'b1;
            res_o.term = 1'b1;
            res_o.ovf  = ovf_q;
            ovf_d      = 1'b0;
            state_d    = S_CMD;
          end
        end
      end
      default: state_d = S_CMD;
    endcase

    // a push onto a full stack is dropped and remembered
    if (do_push && (count_q == CW'(STACK_DEPTH))) begin
      ovf_d = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    if (do_pop) begin
      count_d = count_q - 1'b1;
      top_d   = below_q;
    end else if (do_push && (count_q != CW'(STACK_DEPTH))) begin
      count_d = count_q + 1'b1;
      top_d   = push_ch;
    end
  end

  // below_q tracks the entry under the top for the next cycle
  assign rd_full = count_d - CW'(2);
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CMD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    top_q   <= top_d;
    below_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (do_push && (count_q != CW'(STACK_DEPTH))) begin
      stack_mem[count_q[AW-1:0]] <= push_ch;
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_NEVER(a_push_full, res_push_o && res_full_i, "result written into full queue")
  `ASSERT_CLK(a_term_empty, (res_push_o && res_o.term) |-> (count_q == '0),
              "terminator with entries left on the stack")
  `ASSERT_CLK(a_ovf_clear, (res_push_o && res_o.term) |=> !ovf_q,
              "overflow flag survived the terminator")

endmodule

### dv/infix_to_postfix_converter_core_test.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_test
// drives infix expression characters through the converter and checks every
// postfix result against a shunting-yard predictor kept inside the bench
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2p_pkg::*;

  localparam int DEPTH       = 32;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 370;

  typedef struct {
    logic [7:0] ch;
    logic       eoe;
    bit         drain_first;
  } char_item_t;

  typedef enum int {
    RX_STREAM,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_char = '0;
  logic       end_of_expr = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       is_term;
  logic       ovf_seen;

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .in_char_i          (in_char),
    .end_of_expression_i(end_of_expr),
    .empty              (empty),
    .pop                (pop),
    .out_char_o         (out_char),
    .last_of_run_o      (last_of_run),
    .is_terminator_o    (is_term),
    .overflow_seen_o    (ovf_seen)
  );

  // predictor state
  logic [7:0]  op_stack [DEPTH];
  int unsigned op_depth = 0;
  bit          ovf_pending = 1'b0;
  result_t     postfix_expected [$];

  char_item_t  pending_chars [$];
  int          total_chars = 0;
  int          chars_accepted = 0;
  int          results_taken = 0;
  int          mismatch_count = 0;
  int          stuck_cycles = 0;
  bit          item_taken = 1'b0;
  bit          result_taken = 1'b0;
  result_t     want;

  int          send_burst = 20;
  int          send_gap = 0;
  rx_pattern_e rx_mode = RX_STREAM;
  int          rx_mode_left = 40;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int op_priority(input logic [7:0] ch);
    case (ch)
      CH_CARET:          return 3;
      CH_STAR, CH_SLASH: return 2;
      CH_PLUS, CH_MINUS: return 1;
      default:           return 0;
    endcase
  endfunction

  function automatic bit is_alpha(input logic [7:0] ch);
    return (ch >= CH_LOW_A && ch <= CH_LOW_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z);
  endfunction

  function automatic result_t make_result(input logic [7:0] ch, input logic term,
                                          input logic ovf);
    result_t r;
    r.ch   = ch;
    r.last = 1'b0;
    r.term = term;
    r.ovf  = term & ovf;
    return r;
  endfunction

  task automatic stack_char(input logic [7:0] ch);
    if (op_depth >= DEPTH) begin
      ovf_pending = 1'b1;
    end else begin
      op_stack[op_depth] = ch;
      op_depth++;
    end
  endtask

  task automatic convert_char(input logic [7:0] ch, input logic eoe);
    result_t run [$];
    int      prio;
    if (is_alpha(ch)) begin
      run.push_back(make_result(ch, 1'b0, 1'b0));
    end else if (ch == CH_LPAREN) begin
      stack_char(ch);
    end else if (ch == CH_RPAREN) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CH_LPAREN) begin
        run.push_back(make_result(op_stack[op_depth-1], 1'b0, 1'b0));
        op_depth--;
      end
      // the matching open paren is dropped, if there is one
      if (op_depth > 0) op_depth--;
    end else begin
      prio = op_priority(ch);
      while (op_depth > 0 && prio <= op_priority(op_stack[op_depth-1])) begin
        run.push_back(make_result(op_stack[op_depth-1], 1'b0, 1'b0));
        op_depth--;
      end
      stack_char(ch);
    end
    if (eoe) begin
      while (op_depth > 0) begin
        run.push_back(make_result(op_stack[op_depth-1], 1'b0, 1'b0));
        op_depth--;
      end
      run.push_back(make_result(CH_NUL, 1'b1, ovf_pending));
      ovf_pending = 1'b0;
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) postfix_expected.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h (result %0d)", name, got, exp_val,
                                results_taken));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_char(input logic [7:0] ch, input logic eoe, input bit drain_first);
    char_item_t it;
    it.ch          = ch;
    it.eoe         = eoe;
    it.drain_first = drain_first;
    pending_chars.push_back(it);
  endtask

  // a few characters of a well-formed expression get swapped for a random byte
  task automatic add_noisy(input logic [7:0] ch);
    if ($urandom_range(0, 99) < 4) add_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    else add_char(ch, 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1) == 0) return CH_LOW_A + 8'($urandom_range(0, 25));
    return CH_UP_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  task automatic add_expression();
    int operands;
    int nest;
    int pick;
    bit broken;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // deep nesting, fills the stack near or past its top
      operands = $urandom_range(DEPTH - 4, DEPTH + 8);
      for (int i = 0; i < operands; i++)
        add_char((i % 2 == 0) ? CH_LPAREN : pick_operator(), 1'b0, 1'b0);
      add_char(pick_letter(), 1'b1, 1'b0);
    end else if (pick < 16) begin
      operands = $urandom_range(1, 8);
      for (int i = 0; i < operands; i++)
        add_char(8'($urandom_range(0, 255)), (i == operands - 1), 1'b0);
    end else begin
      operands = $urandom_range(1, 10);
      nest     = 0;
      broken   = ($urandom_range(0, 99) < 15);
      for (int i = 0; i < operands; i++) begin
        while (nest < 6 && $urandom_range(0, 99) < 25) begin
          add_noisy(CH_LPAREN);
          nest++;
        end
        add_noisy(pick_letter());
        while (nest > 0 && $urandom_range(0, 99) < 30) begin
          add_noisy(CH_RPAREN);
          nest--;
        end
        if (i != operands - 1) add_noisy(pick_operator());
      end
      if (!broken) begin
        while (nest > 0) begin
          add_noisy(CH_RPAREN);
          nest--;
        end
      end else if ($urandom_range(0, 1) == 0) begin
        add_noisy(CH_RPAREN);
      end else begin
        add_noisy(pick_operator());
      end
      pending_chars[pending_chars.size()-1].eoe = 1'b1;
    end
  endtask

  task automatic build_stimulus();
    int dir_n;
    add_char(CH_LOW_A, 1'b0, 1'b0);
    add_char(CH_PLUS, 1'b0, 1'b0);
    add_char(CH_UP_Z, 1'b0, 1'b0);
    add_char(CH_STAR, 1'b0, 1'b0);
    add_char(CH_UP_A, 1'b0, 1'b0);
    add_char(CH_CARET, 1'b0, 1'b0);
    add_char(CH_LOW_Z, 1'b0, 1'b0);
    add_char(CH_CARET, 1'b0, 1'b0);
    add_char(CH_LPAREN, 1'b0, 1'b0);
    add_char(CH_LOW_A + 8'd1, 1'b0, 1'b0);
    add_char(CH_MINUS, 1'b0, 1'b0);
    add_char(CH_LOW_A + 8'd2, 1'b0, 1'b0);
    add_char(CH_SLASH, 1'b0, 1'b0);
    add_char(CH_LOW_A + 8'd3, 1'b0, 1'b0);
    add_char(CH_RPAREN, 1'b0, 1'b0);
    // bytes just outside the letter ranges are rank 0 operators
    add_char(CH_UP_A - 8'd1, 1'b0, 1'b0);
    add_char(CH_UP_Z + 8'd1, 1'b0, 1'b0);
    add_char(CH_RPAREN, 1'b0, 1'b0);
    add_char(CH_NUL, 1'b1, 1'b0);
    // close paren with nothing stacked
    add_char(CH_RPAREN, 1'b1, 1'b0);
    add_char(CH_LOW_A - 8'd1, 1'b0, 1'b0);
    add_char(CH_LOW_Z + 8'd1, 1'b0, 1'b0);
    add_char(8'hFF, 1'b1, 1'b0);
    add_char(CH_LPAREN, 1'b1, 1'b0);
    add_char(CH_MINUS, 1'b0, 1'b0);
    add_char(CH_PLUS, 1'b1, 1'b0);
    // full stack plus one dropped push, then a letter that flushes it all
    for (int i = 0; i <= DEPTH; i++) add_char(CH_LPAREN, 1'b0, (i == 0));
    add_char(CH_LOW_A + 8'd16, 1'b1, 1'b0);
    // overflow must not leak into the next expression
    add_char(CH_UP_A + 8'd23, 1'b1, 1'b0);
    dir_n = pending_chars.size();
    while (pending_chars.size() < RAND_ITEMS) add_expression();
    pending_chars[$urandom_range(dir_n + 100, pending_chars.size() - 50)].drain_first = 1'b1;
    total_chars = pending_chars.size();
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (item_taken) pending_chars.delete(0);
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_chars.size() == 0) begin
        push <= 1'b0;
      end else if (pending_chars[0].drain_first && postfix_expected.size() != 0) begin
        push <= 1'b0;
      end else begin
        push        <= 1'b1;
        in_char     <= pending_chars[0].ch;
        end_of_expr <= pending_chars[0].eoe;
        if (send_burst > 1) begin
          send_burst--;
        end else begin
          send_burst = $urandom_range(1, 48);
          send_gap   = $urandom_range(1, 10);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: switches between stall patterns, one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_taken >= 120) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_pattern_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(16, 96);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          RX_STREAM: pop <= 1'b1;
          RX_HALF:   pop <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:   pop <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: handshakes, result check and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      item_taken   = push && !full;
      result_taken = pop && !empty;
      if (item_taken) begin
        convert_char(in_char, end_of_expr);
        chars_accepted++;
      end
      if (result_taken) begin
        results_taken++;
        if (postfix_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result out_char %02h term %0b",
                                    out_char, is_term));
        end else begin
          want = postfix_expected.pop_front();
          check_field("out_char", out_char, want.ch);
          check_field("last_of_run", last_of_run, want.last);
          check_field("is_terminator", is_term, want.term);
          check_field("overflow_seen", ovf_seen, want.ovf);
        end
      end
      if (item_taken || result_taken) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("infix_to_postfix_converter_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (chars_accepted < total_chars) @(posedge clk_i);
    while (postfix_expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("infix_to_postfix_converter_core verification clean");
    end else begin
      $display("infix_to_postfix_converter_core verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_fifo.sv
rtl/i2p_front.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter_core.sv
dv/infix_to_postfix_converter_core_test.sv
